[rtl/xxh64_stream_hash_assert.svh]
// Assertion macros used by the checker file.
`ifndef XXH64_STREAM_HASH_ASSERT_SVH
`define XXH64_STREAM_HASH_ASSERT_SVH

// Assert that a condition implies another in the same cycle.
`define XXH_ASSERT_IMP(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error("assertion failed");

// Assert that a condition implies another in the next cycle.
`define XXH_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error("assertion failed");

`endif

[rtl/xxh_pkg.sv]
// Package with XXH64 primes, the state machine type and helpers.
package xxh_pkg;

  localparam logic [63:0] Prime1 = 64'd11400714785074694791;
  localparam logic [63:0] Prime2 = 64'd14029467366897019727;
  localparam logic [63:0] Prime3 = 64'd1609587929392839161;
  localparam logic [63:0] Prime4 = 64'd9650029242287828579;
  localparam logic [63:0] Prime5 = 64'd2870177450012600261;

  // Sequencer states, one-hot.
  typedef enum logic [8:0] {
    StIdle  = 9'b000000001,
    StRound = 9'b000000010,  // acc += in*P2 -> rot31 -> *P1
    StMrgA  = 9'b000000100,  // merge: h = (h ^ r) * P1 + P4
    StTailW = 9'b000001000,  // buffered word: h = rot27(h ^ r) * P1 + P4
    StTail4 = 9'b000010000,  // four-byte step
    StTail1 = 9'b000100000,  // single-byte step
    StFinA  = 9'b001000000,  // avalanche first multiply
    StFinB  = 9'b010000000,  // avalanche second multiply
    StOut   = 9'b100000000
  } state_e;

  function automatic logic [63:0] rotl(input logic [63:0] x, input logic [5:0] r);
    logic [127:0] d;
    d = {x, x} << r;
    return d[127:64];
  endfunction

endpackage

[rtl/xxh64_stream_hash.sv]
// XXH64 stream hasher (seed 0) built around one shared 32x32 multiplier.
// Words come in little-endian, 64 bits each, and the digest leaves on the last
// word. Every 64-bit product is built from three 32x32 partial products, one per
// cycle. A non-last word that only fills the stripe buffer is written into it as
// it is accepted. A word that closes a 32-byte stripe runs four lane rounds of
// two products each, and the next word is not taken until they are done. The
// last word adds up to 4 merge steps, a step that adds the length, up to 3
// buffered-word steps, at most one 4-byte step, up to 3 byte steps and an
// avalanche. The digest then waits in the output register until it is taken,
// and no word is accepted meanwhile. Every step but the length step passes
// through the single multiplier.
module xxh64_stream_hash (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] data_word_i,
  input  logic [3:0]  valid_bytes_i,
  input  logic        last_word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] digest_o
);

  xxh_pkg::state_e state_q, state_d;
  logic [63:0] lane_q [4];
  logic [63:0] lane_d [4];
  logic [63:0] buf_q [3];
  logic [1:0]  pos_q, pos_d;
  logic [31:0] len_q, len_d;
  logic        full_q, full_d;
  logic [63:0] word_q, word_d;
  logic [3:0]  nb_q, nb_d;
  logic        last_q, last_d;
  logic [63:0] h_q, h_d;
  logic [63:0] t_q, t_d;      // round temp
  logic [1:0]  idx_q, idx_d;  // lane / buffer index
  logic        ph_q, ph_d;    // step phase
  logic [2:0]  bi_q, bi_d;    // byte index
  logic        mrg_q, mrg_d;  // round belongs to a merge
  logic        wr_buf;
  logic [63:0] ma, mb, prod;
  logic [1:0]  mstep_q, mstep_d;
  logic [63:0] macc_q, macc_d;
  logic [31:0] pa, pb;
  logic [63:0] pp;
  logic        mul_use;
  logic        adv;

  // Build the low 64 bits of ma*mb from three partial products: lo*lo, then both cross terms.
  always_comb begin
    unique case (mstep_q)
      2'd1: begin
        pa = ma[31:0]; pb = mb[63:32];
      end
      2'd2: begin
        pa = ma[63:32]; pb = mb[31:0];
      end
      default: begin
        pa = ma[31:0]; pb = mb[31:0];
      end
    endcase
  end

  assign pp = {32'd0, pa} * {32'd0, pb};
  assign prod = {macc_q[63:32] + pp[31:0], macc_q[31:0]};
  assign macc_d = (mstep_q == 2'd0) ? pp : prod;

  // Every sequencer state but idle, output and the length step waits for a product.
  assign mul_use = !((state_q == xxh_pkg::StIdle) || (state_q == xxh_pkg::StOut) ||
                     ((state_q == xxh_pkg::StTailW) && ph_q));
  assign adv = !mul_use || (mstep_q == 2'd2);
  assign mstep_d = adv ? 2'd0 : mstep_q + 2'd1;

  assign in_ready_o = (state_q == xxh_pkg::StIdle);
  assign out_valid_o = (state_q == xxh_pkg::StOut);
  assign digest_o = h_q;

  // Start the finish sequence after the stripe work is done.
  function automatic logic [63:0] merge_start(input logic [63:0] l0, input logic [63:0] l1,
                                              input logic [63:0] l2, input logic [63:0] l3);
    return xxh_pkg::rotl(l0, 6'd1) + xxh_pkg::rotl(l1, 6'd7) +
           xxh_pkg::rotl(l2, 6'd12) + xxh_pkg::rotl(l3, 6'd18);
  endfunction

  always_comb begin
    logic [63:0] hs;
    state_d = state_q;
    for (int k = 0; k < 4; k++) lane_d[k] = lane_q[k];
    pos_d = pos_q; len_d = len_q; full_d = full_q;
    word_d = word_q; nb_d = nb_q; last_d = last_q;
    h_d = h_q; t_d = t_q; idx_d = idx_q; ph_d = ph_q; bi_d = bi_q; mrg_d = mrg_q;
    wr_buf = 1'b0;
    ma = h_q; mb = xxh_pkg::Prime1;
    hs = (full_q ? h_q : xxh_pkg::Prime5) + {32'd0, len_q};
    unique case (state_q)
      xxh_pkg::StIdle: begin
        if (in_valid_i) begin
          word_d = data_word_i;
          last_d = last_word_i;
          nb_d = (!last_word_i || valid_bytes_i > 4'd8) ? 4'd8 : valid_bytes_i;
          len_d = len_q + {28'd0, nb_d};
          ph_d = 1'b0;
          if (nb_d == 4'd8 && pos_q == 2'd3) begin
            idx_d = 2'd0; mrg_d = 1'b0; state_d = xxh_pkg::StRound;
            nb_d = 4'd0;
          end else begin
            if (nb_d == 4'd8) begin
              wr_buf = 1'b1; pos_d = pos_q + 2'd1; nb_d = 4'd0;
            end
            if (last_word_i) begin
              h_d = merge_start(lane_q[0], lane_q[1], lane_q[2], lane_q[3]);
              idx_d = 2'd0; mrg_d = 1'b1;
              state_d = full_q ? xxh_pkg::StRound : xxh_pkg::StTailW;
              if (!full_q) begin h_d = xxh_pkg::Prime5; ph_d = 1'b1; end
            end
          end
        end
      end
      // Lane round: ph 0: t = in*P2 ; ph 1: acc = rot31(acc+t)*P1 (merge: h ^= rot31(t)*P1)
      xxh_pkg::StRound: begin
        if (!ph_q) begin
          ma = mrg_q ? lane_q[idx_q] : (idx_q == 2'd3 ? word_q : buf_q[idx_q]);
          mb = xxh_pkg::Prime2;
          t_d = prod; ph_d = 1'b1;
        end else begin
          ma = xxh_pkg::rotl((mrg_q ? 64'd0 : lane_q[idx_q]) + t_q, 6'd31);
          mb = xxh_pkg::Prime1;
          ph_d = 1'b0;
          if (mrg_q) begin
            h_d = h_q ^ prod; state_d = xxh_pkg::StMrgA;
          end else begin
            lane_d[idx_q] = prod;
            idx_d = idx_q + 2'd1;
            if (idx_q == 2'd3) begin
              pos_d = 2'd0; full_d = 1'b1;
              if (last_q) begin
                h_d = merge_start(lane_d[0], lane_d[1], lane_d[2], lane_d[3]);
                idx_d = 2'd0; mrg_d = 1'b1;
              end else begin
                state_d = xxh_pkg::StIdle;
              end
            end
          end
        end
      end
      xxh_pkg::StMrgA: begin
        ma = h_q; mb = xxh_pkg::Prime1;
        h_d = prod + xxh_pkg::Prime4;
        idx_d = idx_q + 2'd1;
        state_d = (idx_q == 2'd3) ? xxh_pkg::StTailW : xxh_pkg::StRound;
        ph_d = (idx_q == 2'd3) ? 1'b1 : 1'b0;
      end
      // Buffered words: ph 1 entry adds length; then t=b*P2, h^=rot31(t)*P1, rot27*P1+P4
      xxh_pkg::StTailW: begin
        if (ph_q) begin
          // entry: fold in length, then pick next step
          h_d = hs; idx_d = 2'd0; ph_d = 1'b0; bi_d = 3'd0;
          if (pos_q == 2'd0) begin
            state_d = (nb_q >= 4'd4) ? xxh_pkg::StTail4 :
                      (nb_q != 4'd0) ? xxh_pkg::StTail1 : xxh_pkg::StFinA;
            ma = hs ^ (hs >> 33); mb = xxh_pkg::Prime2;
            if (nb_q == 4'd0) h_d = (hs ^ (hs >> 33));
          end
          t_d = 64'd0;
        end else if (mrg_q) begin
          ma = buf_q[idx_q]; mb = xxh_pkg::Prime2;
          t_d = prod; mrg_d = 1'b0; ph_d = 1'b0;
          bi_d = 3'd1;
        end
        if (!ph_q && bi_q == 3'd1) begin
          ma = xxh_pkg::rotl(t_q, 6'd31); mb = xxh_pkg::Prime1;
          h_d = h_q ^ prod; bi_d = 3'd2; t_d = t_q;
        end else if (!ph_q && bi_q == 3'd2) begin
          ma = xxh_pkg::rotl(h_q, 6'd27); mb = xxh_pkg::Prime1;
          h_d = prod + xxh_pkg::Prime4; bi_d = 3'd0; mrg_d = 1'b1;
          idx_d = idx_q + 2'd1;
          if (idx_q + 2'd1 == pos_q) begin
            state_d = (nb_q >= 4'd4) ? xxh_pkg::StTail4 :
                      (nb_q != 4'd0) ? xxh_pkg::StTail1 : xxh_pkg::StFinA;
            if (nb_q == 4'd0) h_d = (prod + xxh_pkg::Prime4) ^ ((prod + xxh_pkg::Prime4) >> 33);
          end
        end
        if (ph_q && pos_q != 2'd0) mrg_d = 1'b1;
      end
      xxh_pkg::StTail4: begin
        if (!ph_q) begin
          ma = {32'd0, word_q[31:0]}; mb = xxh_pkg::Prime1;
          h_d = h_q ^ prod; ph_d = 1'b1;
        end else begin
          ma = xxh_pkg::rotl(h_q, 6'd23); mb = xxh_pkg::Prime2;
          h_d = prod + xxh_pkg::Prime3; ph_d = 1'b0; bi_d = 3'd4;
          if (nb_q == 4'd4) begin
            state_d = xxh_pkg::StFinA;
            h_d = (prod + xxh_pkg::Prime3) ^ ((prod + xxh_pkg::Prime3) >> 33);
          end else state_d = xxh_pkg::StTail1;
        end
      end
      xxh_pkg::StTail1: begin
        if (!ph_q) begin
          ma = {56'd0, word_q[{bi_q, 3'b000} +: 8]}; mb = xxh_pkg::Prime5;
          h_d = h_q ^ prod; ph_d = 1'b1;
        end else begin
          ma = xxh_pkg::rotl(h_q, 6'd11); mb = xxh_pkg::Prime1;
          h_d = prod; ph_d = 1'b0; bi_d = bi_q + 3'd1;
          if ({1'b0, bi_q} + 4'd1 == nb_q) begin
            state_d = xxh_pkg::StFinA;
            h_d = prod ^ (prod >> 33);
          end
        end
      end
      xxh_pkg::StFinA: begin
        ma = h_q; mb = xxh_pkg::Prime2;
        h_d = prod ^ (prod >> 29); state_d = xxh_pkg::StFinB;
      end
      xxh_pkg::StFinB: begin
        ma = h_q; mb = xxh_pkg::Prime3;
        h_d = prod ^ (prod >> 32); state_d = xxh_pkg::StOut;
      end
      xxh_pkg::StOut: begin
        if (out_ready_i) begin
          state_d = xxh_pkg::StIdle;
          lane_d[0] = xxh_pkg::Prime1 + xxh_pkg::Prime2;
          lane_d[1] = xxh_pkg::Prime2;
          lane_d[2] = 64'd0;
          lane_d[3] = 64'd0 - xxh_pkg::Prime1;
          pos_d = 2'd0; len_d = 32'd0; full_d = 1'b0;
        end
      end
      default: state_d = xxh_pkg::StIdle;
    endcase
  end

  // Hold the control state; advance only once the product is complete.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= xxh_pkg::StIdle;
      lane_q[0] <= xxh_pkg::Prime1 + xxh_pkg::Prime2;
      lane_q[1] <= xxh_pkg::Prime2;
      lane_q[2] <= 64'd0;
      lane_q[3] <= 64'd0 - xxh_pkg::Prime1;
      pos_q <= 2'd0; len_q <= 32'd0; full_q <= 1'b0;
      idx_q <= 2'd0; ph_q <= 1'b0; bi_q <= 3'd0; mrg_q <= 1'b0;
      mstep_q <= 2'd0;
    end else begin
      mstep_q <= mstep_d;
      if (adv) begin
        state_q <= state_d;
        for (int k = 0; k < 4; k++) lane_q[k] <= lane_d[k];
        pos_q <= pos_d; len_q <= len_d; full_q <= full_d;
        idx_q <= idx_d; ph_q <= ph_d; bi_q <= bi_d; mrg_q <= mrg_d;
      end
    end
  end

  // Hold the payload registers and the partial product.
  always_ff @(posedge clk_i) begin
    macc_q <= macc_d;
    if (adv) begin
      word_q <= word_d; nb_q <= nb_d; last_q <= last_d;
      h_q <= h_d; t_q <= t_d;
    end
    if (wr_buf) buf_q[pos_q] <= data_word_i;
  end

endmodule

[rtl/xxh64_stream_hash_checker.sv]
// Port-level checker for the XXH64 hasher, bound to the top level.
`include "xxh64_stream_hash_assert.svh"
module xxh64_stream_hash_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [63:0] digest_o
);
  `XXH_ASSERT_IMP(a_excl, clk_i, rst_ni, out_valid_o, !in_ready_o)
  `XXH_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(digest_o))
  `XXH_ASSERT_NEXT(a_busy, clk_i, rst_ni, in_valid_i && in_ready_o, !out_valid_o)
endmodule

bind xxh64_stream_hash xxh64_stream_hash_checker u_checker (.*);

[verif/xxh64_stream_hash_tb.sv]
// Self-checking testbench for the XXH64 stream hasher.
`timescale 1ns / 1ps

module xxh64_stream_hash_tb;

  // Input item as driven onto the ports
  typedef struct packed {
    logic [63:0] word;
    logic [3:0]  nbytes;
    logic        last;
  } word_item_t;

  // Directed row: item plus an optional typed-in digest
  typedef struct {
    word_item_t  item;
    bit          has_digest;
    logic [63:0] digest;
  } hash_row_t;

  localparam int unsigned MaxCycles = 3000000;
  localparam int unsigned DrainCycles = 200;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [63:0] data_word_i;
  logic [3:0]  valid_bytes_i;
  logic        last_word_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [63:0] digest_o;

  xxh64_stream_hash uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_word_i  (data_word_i),
    .valid_bytes_i(valid_bytes_i),
    .last_word_i  (last_word_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .digest_o     (digest_o)
  );

  // Predictor state
  logic [63:0] lanes_q [4];
  logic [63:0] pend_words [3];
  int unsigned pend_cnt;
  logic [31:0] msg_len;
  bit          folded_any;

  logic [63:0] digest_queue [$];
  int unsigned mismatches;
  int unsigned cycle_cnt;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_off_cycles;

  // Clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic logic [63:0] rot_left(logic [63:0] x, int unsigned r);
    return (x << r) | (x >> (64 - r));
  endfunction

  function automatic logic [63:0] mix_round(logic [63:0] acc, logic [63:0] val);
    acc = acc + val * xxh_pkg::Prime2;
    acc = rot_left(acc, 31);
    return acc * xxh_pkg::Prime1;
  endfunction

  function automatic void clear_hash_state();
    lanes_q[0] = xxh_pkg::Prime1 + xxh_pkg::Prime2;
    lanes_q[1] = xxh_pkg::Prime2;
    lanes_q[2] = 64'd0;
    lanes_q[3] = 64'd0 - xxh_pkg::Prime1;
    for (int k = 0; k < 3; k++) pend_words[k] = 64'd0;
    pend_cnt = 0;
    msg_len = 32'd0;
    folded_any = 1'b0;
  endfunction

  // Advance the hash state by one word; push a digest on the last word
  function automatic void absorb_word(word_item_t it);
    logic [63:0] h;
    int unsigned nb;
    int unsigned k;
    nb = it.nbytes;
    if (!it.last || nb > 8) nb = 8;
    msg_len = msg_len + nb;
    if (nb == 8) begin
      if (pend_cnt == 3) begin
        lanes_q[0] = mix_round(lanes_q[0], pend_words[0]);
        lanes_q[1] = mix_round(lanes_q[1], pend_words[1]);
        lanes_q[2] = mix_round(lanes_q[2], pend_words[2]);
        lanes_q[3] = mix_round(lanes_q[3], it.word);
        pend_cnt = 0;
        folded_any = 1'b1;
      end else begin
        pend_words[pend_cnt] = it.word;
        pend_cnt++;
      end
      nb = 0;
    end
    if (!it.last) return;
    if (folded_any) begin
      h = rot_left(lanes_q[0], 1) + rot_left(lanes_q[1], 7) +
          rot_left(lanes_q[2], 12) + rot_left(lanes_q[3], 18);
      for (int j = 0; j < 4; j++) begin
        h = h ^ mix_round(64'd0, lanes_q[j]);
        h = h * xxh_pkg::Prime1 + xxh_pkg::Prime4;
      end
    end else begin
      h = xxh_pkg::Prime5;
    end
    h = h + {32'd0, msg_len};
    for (int j = 0; j < pend_cnt; j++) begin
      h = h ^ mix_round(64'd0, pend_words[j]);
      h = rot_left(h, 27) * xxh_pkg::Prime1 + xxh_pkg::Prime4;
    end
    k = 0;
    if (nb >= 4) begin
      h = h ^ ({32'd0, it.word[31:0]} * xxh_pkg::Prime1);
      h = rot_left(h, 23) * xxh_pkg::Prime2 + xxh_pkg::Prime3;
      k = 4;
    end
    for (; k < nb; k++) begin
      h = h ^ ({56'd0, it.word[8*k +: 8]} * xxh_pkg::Prime5);
      h = rot_left(h, 11) * xxh_pkg::Prime1;
    end
    h = h ^ (h >> 33);
    h = h * xxh_pkg::Prime2;
    h = h ^ (h >> 29);
    h = h * xxh_pkg::Prime3;
    h = h ^ (h >> 32);
    digest_queue.push_back(h);
    clear_hash_state();
  endfunction

  // Offer one item at the falling edge and hold it until accepted
  task automatic send_word(word_item_t it);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    data_word_i   <= it.word;
    valid_bytes_i <= it.nbytes;
    last_word_i   <= it.last;
    do @(posedge clk_i); while (!in_ready_o);
    absorb_word(it);
    @(negedge clk_i);
  endtask

  function automatic word_item_t rand_word(bit last);
    word_item_t it;
    it.word   = {$urandom, $urandom};
    it.nbytes = $urandom_range(15);
    it.last   = last;
    return it;
  endfunction

  // Random message: mostly short, some spanning several stripes
  task automatic send_message();
    int unsigned len;
    len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(12);
    for (int j = 0; j < len; j++) send_word(rand_word(1'b0));
    send_word(rand_word(1'b1));
  endtask

  task automatic wait_drained();
    while (digest_queue.size() != 0) @(negedge clk_i);
  endtask

  // Receiver: random stall, optional long hold-off
  always @(negedge clk_i) begin
    if (hold_off_cycles != 0) begin
      out_ready_i <= 1'b0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      out_ready_i <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
    end
  end

  // Compare each accepted digest with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (digest_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected digest %h", digest_o);
      end else begin
        logic [63:0] exp_digest;
        exp_digest = digest_queue.pop_front();
        if (digest_o !== exp_digest) begin
          mismatches++;
          if (mismatches <= 10)
            $display("digest mismatch: expected %h, got %h", exp_digest, digest_o);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > MaxCycles) begin
      $display("[xxh64_stream_hash] ERROR");
      $finish;
    end
  end

  initial begin
    hash_row_t   rows [$];
    in_valid_i      = 1'b0;
    data_word_i     = '0;
    valid_bytes_i   = '0;
    last_word_i     = 1'b0;
    out_ready_i     = 1'b0;
    rst_ni          = 1'b0;
    mismatches      = 0;
    cycle_cnt       = 0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    hold_off_cycles = 0;
    clear_hash_state();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed rows; known digests of the empty message typed in
    rows.push_back('{'{64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1'b1}, 1, 64'hEF46DB3751D8E999});
    rows.push_back('{'{64'h0, 4'd0, 1'b1}, 1, 64'hEF46DB3751D8E999});
    rows.push_back('{'{64'h0, 4'd1, 1'b1}, 0, '0});
    rows.push_back('{'{64'hFFFF_FFFF_FFFF_FFFF, 4'd4, 1'b1}, 0, '0});
    rows.push_back('{'{64'hFFFF_FFFF_FFFF_FFFF, 4'd7, 1'b1}, 0, '0});
    rows.push_back('{'{64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1}, 0, '0});
    rows.push_back('{'{64'h0123_4567_89AB_CDEF, 4'd15, 1'b1}, 0, '0});
    rows.push_back('{'{64'hFFFF_FFFF_FFFF_FFFF, 4'd3, 1'b0}, 0, '0});
    rows.push_back('{'{64'h0, 4'd0, 1'b0}, 0, '0});
    rows.push_back('{'{64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b0}, 0, '0});
    rows.push_back('{'{64'hA5A5_5A5A_A5A5_5A5A, 4'd8, 1'b1}, 0, '0});
    for (int j = 0; j < 7; j++)
      rows.push_back('{'{64'h1111_1111_1111_1111 * (j + 1), 4'd8, 1'b0}, 0, '0});
    rows.push_back('{'{64'hDEAD_BEEF_CAFE_F00D, 4'd8, 1'b1}, 0, '0});
    for (int j = 0; j < 5; j++)
      rows.push_back('{'{64'hFFFF_0000_FFFF_0000 ^ j, 4'd8, 1'b0}, 0, '0});
    rows.push_back('{'{64'h8000_0000_0000_0001, 4'd5, 1'b1}, 0, '0});
    foreach (rows[r]) begin
      send_word(rows[r].item);
      if (rows[r].has_digest && digest_queue.size() != 0)
        digest_queue[digest_queue.size() - 1] = rows[r].digest;
    end
    in_valid_i <= 1'b0;
    wait_drained();

    // Random traffic over idling phases
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 84 : (ph == 3) ? 33 : 0;
      recv_stall_pct = (ph == 2) ? 84 : (ph == 3) ? 33 : 0;
      if (ph == 0) hold_off_cycles = 400;
      for (int m = 0; m < 35; m++) send_message();
    end
    in_valid_i <= 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    wait_drained();
    repeat (DrainCycles) @(negedge clk_i);

    if (mismatches == 0 && digest_queue.size() == 0) begin
      $display("[xxh64_stream_hash] OK");
    end else begin
      $display("[xxh64_stream_hash] ERROR");
    end
    $finish;
  end

endmodule

[xxh64_stream_hash.f]
+incdir+rtl
rtl/xxh_pkg.sv
rtl/xxh64_stream_hash.sv
rtl/xxh64_stream_hash_checker.sv
verif/xxh64_stream_hash_tb.sv
